// ----- sv/uvs_pkg.sv -----
package uvs_pkg;

  // index width: holds 0..64 and any effective side count
  localparam int KW = 7;
  // fraction bits of the phase divider
  localparam int FW = 32;
  localparam int CORDIC_STEPS = 24;
  localparam int QDEPTH = 2;
  localparam int DEF_MAX_SIDES = 64;
  localparam logic signed [32:0] CORDIC_START = 33'sd652032874;

  // corner walk: bit k is the ring / band step of corner k
  localparam logic [5:0] RING_STEP = 6'b101100;
  localparam logic [5:0] BAND_STEP = 6'b110010;
  localparam logic [2:0] LAST_CORNER = 3'd5;
  localparam logic [1:0] LAST_SLOT = 2'd3;

  // register indexes
  localparam logic CFG_DIAMETER = 1'b0;
  localparam logic CFG_SIDES = 1'b1;

  typedef struct packed {
    logic [5:0] ring_index;
    logic [5:0] band_index;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [2:0] corner;
    logic last;
  } out_item_t;

  // clamped patch indices held in the queue
  typedef struct packed {
    logic [KW-1:0] ring;
    logic [KW-1:0] band;
  } patch_t;

  // one angle job: slots 0,1 are ring i,i+1; slots 2,3 are band u,u+1
  typedef struct packed {
    logic valid;
    logic [1:0] slot;
    logic [KW-1:0] k;
  } job_t;

  typedef struct packed {
    logic valid;
    logic [1:0] slot;
    logic [31:0] phase;
    logic [16:0] tex;
  } trig_t;

  typedef struct packed {
    logic signed [17:0] c;
    logic signed [17:0] s;
    logic [16:0] tex;
  } ang_t;

  typedef struct packed {
    logic valid;
    logic [1:0] slot;
    ang_t ang;
  } trig_res_t;

  // arctangent of 2^-k in 2^-32 turns
  function automatic logic signed [32:0] atan_turn(input int k);
    logic signed [32:0] v;
    case (k)
      0: v = 33'sd536870912;
      1: v = 33'sd316933406;
      2: v = 33'sd167458907;
      3: v = 33'sd85004756;
      4: v = 33'sd42667331;
      5: v = 33'sd21354465;
      6: v = 33'sd10679838;
      7: v = 33'sd5340245;
      8: v = 33'sd2670163;
      9: v = 33'sd1335087;
      10: v = 33'sd667544;
      11: v = 33'sd333772;
      12: v = 33'sd166886;
      13: v = 33'sd83443;
      14: v = 33'sd41722;
      15: v = 33'sd20861;
      16: v = 33'sd10430;
      17: v = 33'sd5215;
      18: v = 33'sd2608;
      19: v = 33'sd1304;
      20: v = 33'sd652;
      21: v = 33'sd326;
      22: v = 33'sd163;
      23: v = 33'sd81;
      default: v = 33'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/uvs_front.sv -----
module uvs_front import uvs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  in_item_t      in_data,
  input  logic [KW-1:0] n_eff,
  output logic          busy,
  input  logic          q_pop,
  output logic          q_valid,
  output patch_t        q_item
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  patch_t         fifo_r [QDEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           push;
  logic [KW-1:0]  ri, bi;
  patch_t         clamped;

  // saturate indices to the effective side count minus one
  always_comb begin
    ri = KW'(in_data.ring_index);
    bi = KW'(in_data.band_index);
    clamped.ring = (ri >= n_eff) ? n_eff - KW'(1) : ri;
    clamped.band = (bi >= n_eff) ? n_eff - KW'(1) : bi;
  end

  assign busy    = (cnt_r == CW'(QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_item  = fifo_r[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= clamped;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      cnt_r <= cnt_r + CW'(push) - CW'(q_pop);
    end
  end

endmodule

// ----- sv/uvs_phase_div.sv -----
module uvs_phase_div import uvs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [KW-1:0] n_eff,
  input  job_t          job_in,
  output trig_t         ph_out
);

  typedef struct packed {
    logic valid;
    logic [1:0] slot;
    logic ibit;
    logic [KW-1:0] rem;
    logic [FW-1:0] quo;
    logic [16:0] tex;
    logic [31:0] bph;
  } div_st_t;

  div_st_t       st_r   [FW+1];
  div_st_t       st_nxt [FW+1];
  logic [KW-1:0] half;
  logic          fin_inc;

  assign half = n_eff >> 1;

  // one quotient bit per stage: restoring long division of k by n
  always_comb begin
    logic [KW:0] t;
    logic        ge;
    logic        inc;
    st_nxt[0].valid = job_in.valid;
    st_nxt[0].slot  = job_in.slot;
    st_nxt[0].ibit  = (job_in.k >= n_eff);
    st_nxt[0].rem   = (job_in.k >= n_eff) ? job_in.k - n_eff : job_in.k;
    st_nxt[0].quo   = '0;
    st_nxt[0].tex   = '0;
    st_nxt[0].bph   = '0;
    for (int j = 1; j <= FW; j++) begin
      st_nxt[j] = st_r[j-1];
      t  = {st_r[j-1].rem, 1'b0};
      ge = (t >= {1'b0, n_eff});
      st_nxt[j].rem = ge ? KW'(t - {1'b0, n_eff}) : t[KW-1:0];
      st_nxt[j].quo = {st_r[j-1].quo[FW-2:0], ge};
      // round up when remainder plus half reaches n
      inc = (({1'b0, st_nxt[j].rem} + {1'b0, half}) >= {1'b0, n_eff});
      if (j == 16) begin
        st_nxt[j].tex = {st_r[j-1].ibit, st_nxt[j].quo[15:0]} + 17'(inc);
      end
      if (j == 31) begin
        st_nxt[j].bph = {st_r[j-1].ibit, st_nxt[j].quo[30:0]} + 32'(inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= FW; j++) begin
        st_r[j].valid <= 1'b0;
      end
    end else begin
      for (int j = 0; j <= FW; j++) begin
        st_r[j] <= st_nxt[j];
      end
    end
  end

  // ring phase wraps modulo one turn
  assign fin_inc = (({1'b0, st_r[FW].rem} + {1'b0, half}) >= {1'b0, n_eff});

  always_comb begin
    ph_out.valid = st_r[FW].valid;
    ph_out.slot  = st_r[FW].slot;
    ph_out.tex   = st_r[FW].tex;
    ph_out.phase = st_r[FW].slot[1] ? st_r[FW].bph : st_r[FW].quo + 32'(fin_inc);
  end

endmodule

// ----- sv/uvs_cordic.sv -----
module uvs_cordic import uvs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  trig_t     ph_in,
  output trig_res_t res_out
);

  typedef struct packed {
    logic valid;
    logic [1:0] slot;
    logic [1:0] quad;
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
    logic [16:0] tex;
  } cst_t;

  cst_t      cs_r   [CORDIC_STEPS+1];
  cst_t      cs_nxt [CORDIC_STEPS+1];
  trig_res_t res_r;

  // quadrant split, then one rotation per stage
  always_comb begin
    logic signed [32:0] dx, dy;
    cs_nxt[0].valid = ph_in.valid;
    cs_nxt[0].slot  = ph_in.slot;
    cs_nxt[0].quad  = ph_in.phase[31:30];
    cs_nxt[0].x     = CORDIC_START;
    cs_nxt[0].y     = '0;
    cs_nxt[0].z     = {3'b000, ph_in.phase[29:0]};
    cs_nxt[0].tex   = ph_in.tex;
    for (int j = 1; j <= CORDIC_STEPS; j++) begin
      cs_nxt[j] = cs_r[j-1];
      dx = cs_r[j-1].y >>> (j - 1);
      dy = cs_r[j-1].x >>> (j - 1);
      if (!cs_r[j-1].z[32]) begin
        cs_nxt[j].x = cs_r[j-1].x - dx;
        cs_nxt[j].y = cs_r[j-1].y + dy;
        cs_nxt[j].z = cs_r[j-1].z - atan_turn(j - 1);
      end else begin
        cs_nxt[j].x = cs_r[j-1].x + dx;
        cs_nxt[j].y = cs_r[j-1].y - dy;
        cs_nxt[j].z = cs_r[j-1].z + atan_turn(j - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= CORDIC_STEPS; j++) begin
        cs_r[j].valid <= 1'b0;
      end
    end else begin
      for (int j = 0; j <= CORDIC_STEPS; j++) begin
        cs_r[j] <= cs_nxt[j];
      end
    end
  end

  function automatic logic signed [17:0] to_q16(input logic signed [32:0] v);
    logic signed [32:0] r;
    r = (v + 33'sd8192) >>> 14;
    if (r > 33'sd65536) return 18'sd65536;
    if (r < -33'sd65536) return -18'sd65536;
    return r[17:0];
  endfunction

  // round to Q16 and fold the quadrant back in
  always_ff @(posedge clk) begin
    logic signed [17:0] c0, s0;
    c0 = to_q16(cs_r[CORDIC_STEPS].x);
    s0 = to_q16(cs_r[CORDIC_STEPS].y);
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else begin
      res_r.valid <= cs_r[CORDIC_STEPS].valid;
    end
    res_r.slot    <= cs_r[CORDIC_STEPS].slot;
    res_r.ang.tex <= cs_r[CORDIC_STEPS].tex;
    case (cs_r[CORDIC_STEPS].quad)
      2'd0: begin res_r.ang.c <= c0;  res_r.ang.s <= s0;  end
      2'd1: begin res_r.ang.c <= -s0; res_r.ang.s <= c0;  end
      2'd2: begin res_r.ang.c <= -c0; res_r.ang.s <= -s0; end
      default: begin res_r.ang.c <= s0; res_r.ang.s <= -c0; end
    endcase
  end

  assign res_out = res_r;

endmodule

// ----- sv/uvs_back.sv -----
module uvs_back import uvs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [KW-1:0] n_eff,
  input  logic [15:0]   diameter,
  input  logic          q_valid,
  input  patch_t        q_item,
  output logic          q_pop,
  output logic          out_valid,
  output out_item_t     out_data
);

  // ---------------- angle job issue ----------------
  logic          act_r;
  logic [2:0]    cnt_r;
  patch_t        cur_r;
  job_t          job;
  trig_t         ph;
  trig_res_t     res;

  assign q_pop = q_valid && (!act_r || cnt_r == LAST_CORNER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= '0;
    end else if (q_pop) begin
      act_r <= 1'b1;
      cnt_r <= '0;
    end else if (act_r) begin
      act_r <= (cnt_r != LAST_CORNER);
      cnt_r <= cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_item;
    end
  end

  // four jobs per patch: ring i, i+1, band u, u+1
  always_comb begin
    job.valid = act_r && !cnt_r[2];
    job.slot  = cnt_r[1:0];
    job.k     = (cnt_r[1] ? cur_r.band : cur_r.ring) + KW'(cnt_r[0]);
  end

  uvs_phase_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .n_eff  (n_eff),
    .job_in (job),
    .ph_out (ph)
  );

  uvs_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .ph_in   (ph),
    .res_out (res)
  );

  // ---------------- collect angles ----------------
  ang_t       col_r [3];
  ang_t       e_r   [4];
  logic       eact_r;
  logic [2:0] ecnt_r;

  always_ff @(posedge clk) begin
    if (res.valid) begin
      case (res.slot)
        2'd0: col_r[0] <= res.ang;
        2'd1: col_r[1] <= res.ang;
        2'd2: col_r[2] <= res.ang;
        default: begin
          e_r[0] <= col_r[0];
          e_r[1] <= col_r[1];
          e_r[2] <= col_r[2];
          e_r[3] <= res.ang;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eact_r <= 1'b0;
      ecnt_r <= '0;
    end else if (res.valid && res.slot == LAST_SLOT) begin
      eact_r <= 1'b1;
      ecnt_r <= '0;
    end else if (eact_r) begin
      eact_r <= (ecnt_r != LAST_CORNER);
      ecnt_r <= ecnt_r + 3'd1;
    end
  end

  // ---------------- vertex emit ----------------
  ang_t               ra, ba;
  logic signed [16:0] dsg;

  assign dsg = $signed({1'b0, diameter});

  always_comb begin
    ra = RING_STEP[ecnt_r] ? e_r[1] : e_r[0];
    ba = BAND_STEP[ecnt_r] ? e_r[3] : e_r[2];
  end

  function automatic logic [15:0] sat16(input logic signed [52:0] v);
    if (v > 53'sd32767) return 16'h7FFF;
    if (v < -53'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic logic [15:0] nclamp(input logic signed [35:0] v);
    if (v > 36'sd16384) return 16'h4000;
    if (v < -36'sd16384) return 16'hC000;
    return v[15:0];
  endfunction

  // stage 1: ring sine and cosine times band sine, and diameter times band cosine
  logic signed [35:0] p1_r, p2_r;
  logic signed [34:0] p3_r;
  logic signed [17:0] cb_r;
  logic [16:0]        tu1_r, tv1_r;
  logic [2:0]         cor1_r;
  logic               v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= eact_r;
    end
    p1_r   <= ra.s * ba.s;
    p2_r   <= ra.c * ba.s;
    p3_r   <= dsg * ba.c;
    cb_r   <= ba.c;
    tu1_r  <= ra.tex;
    tv1_r  <= ba.tex;
    cor1_r <= ecnt_r;
  end

  // stage 2: scale by diameter, round normals and y
  logic signed [52:0] q1_r, q2_r;
  logic [15:0]        py2_r, nx2_r, ny2_r, nz2_r;
  logic [16:0]        tu2_r, tv2_r;
  logic [2:0]         cor2_r;
  logic               v2_r;

  always_ff @(posedge clk) begin
    logic signed [52:0] p3e;
    logic signed [35:0] cbe;
    p3e = 53'(p3_r);
    cbe = 36'(cb_r);
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    q1_r   <= dsg * p1_r;
    q2_r   <= dsg * p2_r;
    py2_r  <= sat16((p3e + 53'sd65536) >>> 17);
    nx2_r  <= nclamp((p1_r + 36'sd131072) >>> 18);
    nz2_r  <= nclamp((p2_r + 36'sd131072) >>> 18);
    ny2_r  <= nclamp((cbe + 36'sd2) >>> 2);
    tu2_r  <= tu1_r;
    tv2_r  <= tv1_r;
    cor2_r <= cor1_r;
  end

  // stage 3: round and saturate x and z, output register
  logic      v3_r;
  out_item_t o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    o_r.pos_x  <= sat16((q1_r + 53'sd4294967296) >>> 33);
    o_r.pos_y  <= py2_r;
    o_r.pos_z  <= sat16((q2_r + 53'sd4294967296) >>> 33);
    o_r.norm_x <= nx2_r;
    o_r.norm_y <= ny2_r;
    o_r.norm_z <= nz2_r;
    o_r.tex_u  <= tu2_r;
    o_r.tex_v  <= tv2_r;
    o_r.corner <= cor2_r;
    o_r.last   <= (cor2_r == LAST_CORNER);
  end

  assign out_valid = v3_r;
  assign out_data  = o_r;

endmodule

// ----- sv/uvs_top_note.sv -----
module uvs_sides_clamp import uvs_pkg::*; #(
  parameter int MAX_SIDES = DEF_MAX_SIDES
) (
  input  logic [6:0]    sides,
  output logic [KW-1:0] n_eff
);

  // sides below 3 act as 3, above the maximum as the maximum
  always_comb begin
    if (sides < 7'd3) begin
      n_eff = KW'(3);
    end else if (32'(sides) > MAX_SIDES) begin
      n_eff = KW'(MAX_SIDES);
    end else begin
      n_eff = KW'(sides);
    end
  end

endmodule

// ----- sv/uv_sphere_patch_tessellator.sv -----
// UV sphere patch tessellator. Each accepted item (ring and band index) yields
// the six vertices of that patch's two triangles, one vertex per cycle on
// consecutive cycles, the first once the item has passed the queue, phase
// divider, CORDIC and vertex stages. The back end spends one slot per patch,
// feeding four angles through a pipelined 33-stage phase divider and 24-stage
// CORDIC, and takes the next queued patch in the slot's last step, while
// earlier patches are still in flight; the single result port carries one
// vertex per cycle. A two-item queue sits in front; busy is high only while
// it is full. Results are strobed on out_valid for exactly one cycle and
// cannot be held off, so the receiver must take every vertex when it appears.
// Write diameter and sides only while no patch is in flight.
module uv_sphere_patch_tessellator import uvs_pkg::*; #(
  parameter int MAX_SIDES = DEF_MAX_SIDES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_data,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0]   diameter_r;
  logic [6:0]    sides_r;
  logic [KW-1:0] n_eff;
  logic          q_pop, q_valid;
  patch_t        q_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diameter_r <= 16'd256;
      sides_r    <= 7'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIAMETER: diameter_r <= cfg_data;
        CFG_SIDES:    sides_r    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  uvs_sides_clamp #(
    .MAX_SIDES (MAX_SIDES)
  ) u_clamp (
    .sides (sides_r),
    .n_eff (n_eff)
  );

  uvs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_data (in_data),
    .n_eff   (n_eff),
    .busy    (busy),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  uvs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_eff     (n_eff),
    .diameter  (diameter_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import uvs_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  in_item_t    in_data;
  logic        busy;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  uv_sphere_patch_tessellator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data), .busy(busy),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copies of the two registers
  logic [15:0] diam_sh;
  logic [6:0]  sides_sh;
  out_item_t   vertex_q[$];
  int          errors;
  bit          no_gaps;

  longint atan_tab[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("** uv_sphere_patch_tessellator: FAILED **");
    $finish;
  end

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // rotation CORDIC over one quadrant, then quadrant fold; Q16 outputs
  function automatic void sin_cos_q16(input logic [31:0] ph, output longint c,
                                      output longint s);
    longint x, y, z, dx, dy, c0, s0;
    x = 652032874;
    y = 0;
    z = longint'(ph[29:0]);
    for (int k = 0; k < 24; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[k];
      end else begin
        x += dx; y -= dy; z += atan_tab[k];
      end
    end
    c0 = clip((x + 8192) >>> 14, -65536, 65536);
    s0 = clip((y + 8192) >>> 14, -65536, 65536);
    case (ph[31:30])
      2'd0: begin c = c0;  s = s0;  end
      2'd1: begin c = -s0; s = c0;  end
      2'd2: begin c = -c0; s = -s0; end
      default: begin c = s0; s = -c0; end
    endcase
  endfunction

  function automatic out_item_t vertex_at(input int a, input int b, input int n,
                                          input int crn);
    out_item_t o;
    longint half, d, ca, sa, cb, sb, rp, bp;
    half = n / 2;
    d = longint'(diam_sh);
    rp = ((longint'(a) <<< 32) + half) / n;
    bp = ((longint'(b) <<< 31) + half) / n;
    sin_cos_q16(rp[31:0], ca, sa);
    sin_cos_q16(bp[31:0], cb, sb);
    o.pos_x  = 16'(clip((d * sb * sa + (64'sd1 <<< 32)) >>> 33, -32768, 32767));
    o.pos_y  = 16'(clip((d * cb + (64'sd1 <<< 16)) >>> 17, -32768, 32767));
    o.pos_z  = 16'(clip((d * sb * ca + (64'sd1 <<< 32)) >>> 33, -32768, 32767));
    o.norm_x = 16'(clip((sa * sb + (64'sd1 <<< 17)) >>> 18, -16384, 16384));
    o.norm_y = 16'(clip((cb + 2) >>> 2, -16384, 16384));
    o.norm_z = 16'(clip((ca * sb + (64'sd1 <<< 17)) >>> 18, -16384, 16384));
    o.tex_u  = 17'(((longint'(a) <<< 16) + half) / n);
    o.tex_v  = 17'(((longint'(b) <<< 16) + half) / n);
    o.corner = crn[2:0];
    o.last   = (crn[2:0] == LAST_CORNER);
    return o;
  endfunction

  // six corners of one patch, in emission order
  function automatic void predict_patch(input in_item_t it);
    int n, i, u;
    n = int'(sides_sh);
    if (n < 3) n = 3;
    if (n > DEF_MAX_SIDES) n = DEF_MAX_SIDES;
    i = (int'(it.ring_index) >= n) ? n - 1 : int'(it.ring_index);
    u = (int'(it.band_index) >= n) ? n - 1 : int'(it.band_index);
    for (int k = 0; k < 6; k++)
      vertex_q = {vertex_q, vertex_at(i + RING_STEP[k], u + BAND_STEP[k], n, k)};
  endfunction

  task automatic chk(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid) begin
      if (vertex_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected vertex: expected none, actual %h", $time, out_data);
      end else begin
        e = vertex_q.pop_front();
        chk("pos_x", e.pos_x, out_data.pos_x);
        chk("pos_y", e.pos_y, out_data.pos_y);
        chk("pos_z", e.pos_z, out_data.pos_z);
        chk("norm_x", e.norm_x, out_data.norm_x);
        chk("norm_y", e.norm_y, out_data.norm_y);
        chk("norm_z", e.norm_z, out_data.norm_z);
        chk("tex_u", e.tex_u, out_data.tex_u);
        chk("tex_v", e.tex_v, out_data.tex_v);
        chk("corner", e.corner, out_data.corner);
        chk("last", e.last, out_data.last);
      end
    end
  end

  // one patch through the start/busy handshake
  task automatic send_patch(input logic [5:0] ring, input logic [5:0] band);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= '{ring_index: ring, band_index: band};
    do @(posedge clk); while (busy);
    predict_patch('{ring_index: ring, band_index: band});
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DIAMETER) diam_sh = val;
    else sides_sh = val[6:0];
  endtask

  // reset values, corner indices and saturation of indices
  task automatic test_reset_defaults();
    send_patch(6'd0, 6'd0);
    send_patch(6'd2, 6'd2);
    send_patch(6'd63, 6'd63);
    send_patch(6'd3, 6'd0);
  endtask

  // extremes of both registers, including clamped side counts
  task automatic test_register_extremes();
    write_reg(CFG_SIDES, 16'd64);
    write_reg(CFG_DIAMETER, 16'hFFFF);
    send_patch(6'd0, 6'd0);
    send_patch(6'd63, 6'd63);
    send_patch(6'd15, 6'd31);
    write_reg(CFG_DIAMETER, 16'd0);
    send_patch(6'd21, 6'd42);
    for (int j = 0; j < 5; j++) begin
      write_reg(CFG_SIDES, (j == 0) ? 16'd0 : (j == 1) ? 16'd1 : (j == 2) ? 16'd2 :
                (j == 3) ? 16'd65 : 16'd127);
      write_reg(CFG_DIAMETER, (j % 2) ? 16'hFFFF : 16'd256);
      send_patch(6'd63, 6'd0);
      send_patch(6'd0, 6'd63);
    end
  endtask

  // random patches over several register settings
  task automatic test_random_patches();
    int n;
    for (int ph = 0; ph < 9; ph++) begin
      write_reg(CFG_SIDES, 16'($urandom_range(0, 127)));
      if (ph < 3) write_reg(CFG_DIAMETER, 16'($urandom_range(0, 1023)));
      else write_reg(CFG_DIAMETER, 16'($urandom));
      no_gaps = (ph % 3 == 1);
      n = (sides_sh < 7'd3) ? 3 : (sides_sh > 7'd64) ? 64 : int'(sides_sh);
      for (int k = 0; k < 38; k++) begin
        if ($urandom_range(0, 3) != 0)
          send_patch(6'($urandom_range(0, n - 1)), 6'($urandom_range(0, n - 1)));
        else
          send_patch(6'($urandom), 6'($urandom));
        // let the pipeline drain completely now and then
        if (k == 20) begin
          start <= 1'b0;
          while (vertex_q.size() != 0) @(posedge clk);
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    errors = 0;
    no_gaps = 1'b0;
    diam_sh = 16'd256;
    sides_sh = 7'd3;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_DIAMETER;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_random_patches();
    wait_idle();
    if (errors == 0 && vertex_q.size() == 0) begin
      $display("** uv_sphere_patch_tessellator: PASSED **");
    end else begin
      $display("** uv_sphere_patch_tessellator: FAILED **");
    end
    $finish;
  end

endmodule
